>>> design/dts_pkg.sv
// Shared types and constants for the display text sanitizer.
package dts_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CP_W   = 21;
    localparam int CHAR_W = 10;

    localparam logic [CHAR_W-1:0] CH_NUL   = 10'h000;
    localparam logic [CHAR_W-1:0] CH_SPACE = 10'h020;
    localparam logic [CHAR_W-1:0] CH_DASH  = 10'h02D;
    localparam logic [CHAR_W-1:0] CH_APOS  = 10'h027;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 10'h022;
    localparam logic [CHAR_W-1:0] CH_STAR  = 10'h02A;
    localparam logic [CHAR_W-1:0] CH_X     = 10'h078;
    localparam logic [CHAR_W-1:0] CH_DOT   = 10'h02E;

    typedef enum logic [1:0] {
        K_DROP  = 2'd0,
        K_SPACE = 2'd1,
        K_CHAR  = 2'd2,
        K_DOTS  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_token;

endpackage

>>> design/display_text_sanitizer_top.sv
// Top level of the display text sanitizer: front end, token queue, back end.
//
//  channel   dir  handshake                fields (low bit up)
//  s stream  in   i_s_tvalid / o_s_tready  tdata: code_point[20:0]; tlast: end_of_string
//  m stream  out  o_m_tvalid / i_m_tready  tdata: out_char[9:0]; tuser: char_valid;
//                                          tlast: string_done
//
// One code point per cycle for plain characters, spaces and dropped codes while
// the output is not stalled. An ellipsis yields three dots and a character itself,
// each behind a held-back space if one is pending; the back end's single output
// register takes them in turn, while the queue keeps the input running.
// Synchronous active-low reset empties the queue and clears the string state.
// Output stalls fill the queue, then drop o_s_tready.
module display_text_sanitizer_top #(
    parameter int QUEUE_DEPTH = dts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        i_s_tlast,   // end_of_string
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [9:0] out_char, [15:10] zero
    output logic        o_m_tuser,   // char_valid
    output logic        o_m_tlast    // string_done
);
    import dts_pkg::*;

    t_token            front_token, q_token;
    logic              q_full, q_valid, q_pop;
    logic [CHAR_W-1:0] out_char;

    dts_front u_front (
        .i_code_point (i_s_tdata[CP_W-1:0]),
        .i_last       (i_s_tlast),
        .o_token      (front_token)
    );

    dts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_s_tvalid),
        .i_wr_token (front_token),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_token    (q_token)
    );

    dts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_token    (q_token),
        .o_q_pop      (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_char       (out_char),
        .o_char_valid (o_m_tuser),
        .o_done       (o_m_tlast)
    );

    assign o_s_tready = !q_full;
    assign o_m_tdata  = {{(16 - CHAR_W){1'b0}}, out_char};

endmodule

>>> design/dts_front.sv
// Front end: classifies one code point into a token for the back end.
module dts_front (
    input  logic [dts_pkg::CP_W-1:0] i_code_point,
    input  logic                     i_last,
    output dts_pkg::t_token          o_token
);
    import dts_pkg::*;

    always_comb begin
        o_token.last = i_last;
        o_token.ch   = CH_NUL;
        o_token.kind = K_DROP;
        case (i_code_point) inside
            21'h2026: begin
                o_token.kind = K_DOTS;
                o_token.ch   = CH_DOT;
            end
            21'h2014, 21'h2013, 21'h2012, 21'h2010, 21'h2011, 21'h2212,
            21'h00AD, 21'h00AF, 21'h02C9, 21'h00B7: begin
                o_token.kind = K_CHAR;
                o_token.ch   = CH_DASH;
            end
            21'h2018, 21'h2019, 21'h201A, 21'h201B, 21'h2032: begin
                o_token.kind = K_CHAR;
                o_token.ch   = CH_APOS;
            end
            21'h201C, 21'h201D, 21'h201E, 21'h00AB, 21'h00BB: begin
                o_token.kind = K_CHAR;
                o_token.ch   = CH_QUOTE;
            end
            21'h2022, 21'h2023: begin
                o_token.kind = K_CHAR;
                o_token.ch   = CH_STAR;
            end
            21'h00D7: begin
                o_token.kind = K_CHAR;
                o_token.ch   = CH_X;
            end
            // odd spaces, music symbols, daggers, whitespace controls
            21'h00A0, 21'h202F, 21'h2007, 21'h2009, 21'h200A, 21'h200B,
            21'hFEFF, 21'h266A, 21'h266B, 21'h2669, 21'h2020, 21'h2021,
            21'h0009, 21'h000A, 21'h000D, 21'h0020: begin
                o_token.kind = K_SPACE;
                o_token.ch   = CH_SPACE;
            end
            [21'h0021:21'h007E], [21'h00C0:21'h024F]: begin
                o_token.kind = K_CHAR;
                o_token.ch   = i_code_point[CHAR_W-1:0];
            end
            default: begin
                if (i_code_point >= 21'h80) begin
                    o_token.kind = K_SPACE;
                    o_token.ch   = CH_SPACE;
                end
            end
        endcase
    end

endmodule

>>> design/dts_queue.sv
// Short token queue between the front and back ends.
module dts_queue #(
    parameter int DEPTH = dts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  dts_pkg::t_token i_wr_token,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output dts_pkg::t_token o_token
);
    import dts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_token        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_ADDR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_token;
        end
    end

endmodule

>>> design/dts_back.sv
// Back end: space folding, expansion and the output register.
module dts_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  dts_pkg::t_token            i_q_token,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dts_pkg::CHAR_W-1:0] o_char,
    output logic                       o_char_valid,
    output logic                       o_done
);
    import dts_pkg::*;

    logic              r_space_pending, n_space_pending;
    logic              r_text_started, n_text_started;
    logic [1:0]        r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_char_valid, n_char_valid;
    logic              r_done, n_done;

    logic       pre, bare, out_free, load, finish;
    logic [1:0] n_chars;
    logic [2:0] total, emit_count;
    logic [1:0] last_idx;

    always_comb begin
        case (i_q_token.kind)
            K_CHAR:  n_chars = 2'd1;
            K_DOTS:  n_chars = 2'd3;
            default: n_chars = 2'd0;
        endcase
    end

    assign pre = r_space_pending &&
                 (i_q_token.kind == K_CHAR || i_q_token.kind == K_DOTS);
    assign total      = {2'b00, pre} + {1'b0, n_chars};
    assign bare       = (total == 3'd0) && i_q_token.last;
    assign emit_count = bare ? 3'd1 : total;
    assign last_idx   = 2'(emit_count - 3'd1);
    assign out_free   = !r_out_valid || i_ready;
    assign load       = i_q_valid && (emit_count != 3'd0) && out_free;
    // a token with no results retires without touching the output register
    assign finish     = i_q_valid &&
                        ((emit_count == 3'd0) || (load && r_step == last_idx));
    assign o_q_pop    = finish;

    always_comb begin
        n_space_pending = r_space_pending;
        n_text_started  = r_text_started;
        n_step          = r_step;
        n_out_valid     = r_out_valid && !i_ready;
        n_char          = r_char;
        n_char_valid    = r_char_valid;
        n_done          = r_done;

        if (load) begin
            n_out_valid  = 1'b1;
            n_char_valid = !bare;
            n_done       = i_q_token.last && (r_step == last_idx);
            if (bare) begin
                n_char = CH_NUL;
            end else if (pre && r_step == 2'd0) begin
                n_char = CH_SPACE;
            end else begin
                n_char = i_q_token.ch;
            end
            n_step = r_step + 2'd1;
        end

        if (finish) begin
            n_step = 2'd0;
            if (i_q_token.last) begin
                n_space_pending = 1'b0;
                n_text_started  = 1'b0;
            end else if (i_q_token.kind == K_SPACE) begin
                n_space_pending = r_text_started;
            end else if (i_q_token.kind != K_DROP) begin
                n_space_pending = 1'b0;
                n_text_started  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_pending <= 1'b0;
            r_text_started  <= 1'b0;
            r_step          <= 2'd0;
            r_out_valid     <= 1'b0;
        end else begin
            r_space_pending <= n_space_pending;
            r_text_started  <= n_text_started;
            r_step          <= n_step;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char       <= n_char;
        r_char_valid <= n_char_valid;
        r_done       <= n_done;
    end

    assign o_valid      = r_out_valid;
    assign o_char       = r_char;
    assign o_char_valid = r_char_valid;
    assign o_done       = r_done;

`ifndef ASSERT_OFF
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_char_valid |-> r_done && r_char == CH_NUL)
        else $error("bare marker must be a zero end-of-string result");

    a_mid_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 2'd0 |-> i_q_valid)
        else $error("token left the queue before its expansion finished");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish && i_q_token.last |=> !r_space_pending && !r_text_started)
        else $error("string state not cleared at end of string");

    a_space_after_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && n_char == CH_SPACE && n_char_valid |-> r_text_started)
        else $error("space sent before any text");
`endif

endmodule
